// ----- hw/rtl/nsf_pkg.sv -----
// Shared types and codes for the NMEA sentence framer.
package nsf_pkg;

	localparam int PREFIX_LEN = 5;

	// event codes on the result tuser
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_PAYLOAD  = 3'd1;
	localparam logic [2:0] EV_GOOD     = 3'd2;
	localparam logic [2:0] EV_MISMATCH = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;

	// sentence kinds
	localparam logic [2:0] KIND_OTHER   = 3'd0;
	localparam logic [2:0] KIND_RMC     = 3'd1;
	localparam logic [2:0] KIND_GGA     = 3'd2;
	localparam logic [2:0] KIND_GSA     = 3'd3;
	localparam logic [2:0] KIND_GSV     = 3'd4;
	localparam logic [2:0] KIND_PMTK    = 3'd5;
	localparam logic [2:0] KIND_UNKNOWN = 3'd6;

	// constellations
	localparam logic [1:0] CONS_GPS     = 2'd0;
	localparam logic [1:0] CONS_GLONASS = 2'd1;
	localparam logic [1:0] CONS_GALILEO = 2'd2;

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] constellation;
	} class_t;

endpackage

// ----- hw/rtl/nsf_classify.sv -----
// Sentence classifier working on the first five payload characters.
module nsf_classify
	import nsf_pkg::*;
(
	input  prefix_t    prefix,
	input  logic [7:0] payload_length,
	output class_t     cls
);

	logic        len4;
	logic        len5;
	logic [39:0] head5;
	logic [31:0] head4;
	logic [23:0] tail3;
	logic [15:0] talker;
	logic [2:0]  gs_kind;

	assign len4   = payload_length >= 8'd4;
	assign len5   = payload_length >= 8'd5;
	assign head5  = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]};
	assign head4  = {prefix[0], prefix[1], prefix[2], prefix[3]};
	assign tail3  = {prefix[2], prefix[3], prefix[4]};
	assign talker = {prefix[0], prefix[1]};

	always_comb begin
		cls     = '{kind: KIND_OTHER, constellation: CONS_GPS};
		gs_kind = KIND_OTHER;
		if (len5 && tail3 == "GSA") begin
			gs_kind = KIND_GSA;
		end else if (len5 && tail3 == "GSV") begin
			gs_kind = KIND_GSV;
		end
		if (len5 && head5 == "GNRMC") begin
			cls.kind = KIND_RMC;
		end else if (len5 && head5 == "GNGGA") begin
			cls.kind = KIND_GGA;
		end else if (gs_kind != KIND_OTHER) begin
			if (talker == "GP") begin
				cls.kind = gs_kind;
			end else if (talker == "GL") begin
				cls.kind          = gs_kind;
				cls.constellation = CONS_GLONASS;
			end else if (talker == "GA") begin
				cls.kind          = gs_kind;
				cls.constellation = CONS_GALILEO;
			end else begin
				cls.kind = KIND_UNKNOWN;
			end
		end else if (len4 && head4 == "PMTK") begin
			cls.kind = KIND_PMTK;
		end
	end

endmodule

// ----- hw/rtl/nmea_sentence_framer.sv -----
// NMEA 0183 sentence framer: byte stream in, checksum and event items out.
// Each result is registered and appears in the cycle after its input is accepted.
// One item per cycle if m_tready allows; each input yields exactly one result item.
// The single result register is refilled in the cycle it is taken, so s_tready
// follows m_tready combinationally.
// Reset (arst_n low, async): idle, counters cleared, max_length 85, no result pending.
module nmea_sentence_framer
	import nsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // max_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,       // [7:0] data_byte, [10:8] sentence_kind,
	                                   // [12:11] constellation, [20:13] payload_length,
	                                   // [28:21] received_checksum,
	                                   // [36:29] computed_checksum, [39:37] zero
	output logic [2:0]  m_tuser        // [2:0] event_res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_HEX1 = 2'd2;
	localparam logic [1:0] PH_HEX2 = 2'd3;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	logic [7:0] max_len_q;
	logic [1:0] phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0] xor_q, xor_d;
	logic [3:0] hi_q, hi_d;
	prefix_t    prefix_q;
	logic       pfx_we;

	logic       accept;
	logic [7:0] c;
	logic [7:0] len;
	logic [7:0] rx_sum;
	class_t     cls;

	logic [2:0] ev;
	logic [7:0] dout;
	logic [2:0] kind;
	logic [1:0] cons;
	logic [7:0] plen;
	logic [7:0] rx_ck;
	logic [7:0] cp_ck;

	logic       out_valid_q;
	logic [2:0] ev_q;
	logic [7:0] dout_q;
	logic [2:0] kind_q;
	logic [1:0] cons_q;
	logic [7:0] plen_q;
	logic [7:0] rx_ck_q;
	logic [7:0] cp_ck_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata;

	assign cnt_inc = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;
	assign len     = (cnt_q != 8'd0) ? cnt_q - 8'd1 : 8'd0;
	assign rx_sum  = {hi_q, hex_value(c)};

	nsf_classify u_classify (
		.prefix         (prefix_q),
		.payload_length (len),
		.cls            (cls)
	);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		hi_d    = hi_q;
		pfx_we  = 1'b0;
		ev      = EV_NONE;
		dout    = 8'd0;
		kind    = KIND_OTHER;
		cons    = CONS_GPS;
		plen    = 8'd0;
		rx_ck   = 8'd0;
		cp_ck   = 8'd0;
		unique case (phase_q)
			PH_IDLE: begin
				if (c == CH_DOLLAR) begin
					cnt_d   = 8'd0;
					xor_d   = 8'd0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (c == CH_STAR) begin
					phase_d = PH_HEX1;
				end else begin
					xor_d  = xor_q ^ c;
					pfx_we = cnt_q < 8'(PREFIX_LEN);
					ev     = EV_PAYLOAD;
					dout   = c;
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= max_len_q) begin
					ev      = EV_OVERFLOW;
					dout    = 8'd0;
					cnt_d   = 8'd0;
					phase_d = PH_IDLE;
				end
			end
			PH_HEX1: begin
				hi_d    = hex_value(c);
				phase_d = PH_HEX2;
			end
			PH_HEX2: begin
				phase_d = PH_IDLE;
				cnt_d   = 8'd0;
				plen    = len;
				rx_ck   = rx_sum;
				cp_ck   = xor_q;
				if (rx_sum == xor_q) begin
					ev   = EV_GOOD;
					kind = cls.kind;
					cons = cls.constellation;
				end else begin
					ev = EV_MISMATCH;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'd85;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 8'd0;
			xor_q   <= 8'd0;
			hi_q    <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			hi_q    <= hi_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pfx_we) begin
			prefix_q[cnt_q[2:0]] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q    <= ev;
			dout_q  <= dout;
			kind_q  <= kind;
			cons_q  <= cons;
			plen_q  <= plen;
			rx_ck_q <= rx_ck;
			cp_ck_q <= cp_ck;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {3'd0, cp_ck_q, rx_ck_q, plen_q, cons_q, kind_q, dout_q};

endmodule
